[rtl/hcts_pkg.sv]
// ----------------------------------------------------------------------------
// hcts_pkg
// Shared constants and word types for the healthy channel top-two selector.
// ----------------------------------------------------------------------------
package hcts_pkg;

   localparam int CHAN_COUNT = 12;
   localparam int IDX_W      = $clog2(CHAN_COUNT);
   localparam int CH_W       = 4;
   localparam int VOLT_W     = 16;

   localparam logic [VOLT_W-1:0] THRESHOLD_RESET = 16'd12000;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   localparam logic STATUS_OK           = 1'b0;
   localparam logic STATUS_INSUFFICIENT = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [CH_W-1:0]   channel;
      logic [VOLT_W-1:0] voltage;
   } req_word_type;

   typedef struct packed {
      logic              status;
      logic [CH_W-1:0]   best_channel;
      logic [CH_W-1:0]   second_channel;
      logic [VOLT_W-1:0] mean_voltage;
   } rsp_word_type;

endpackage

[rtl/hcts_ram.sv]
// ----------------------------------------------------------------------------
// hcts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hcts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/healthy_channel_top_two_selector_core.sv]
// ----------------------------------------------------------------------------
// healthy_channel_top_two_selector_core
// Keeps the latest voltage per channel and, on a tick, scans the reported
// channels to pick the two highest above the threshold.
//
//   channel | ports                          | moves
//   --------+--------------------------------+------------------------------
//   req     | req_valid req_stall req_data   | update or tick word in
//   rsp     | rsp_valid rsp_stall rsp_data   | one result word per tick
//   csr     | csr_wr_en csr_wr_data          | healthy threshold write
//
// A tick issues one voltage RAM read per channel through a single
// compare path, retires the last read in a drain state, then the result
// waits in its register until taken.
// req_stall is high from tick acceptance until the result word is taken.
// Synchronous reset clears the reported flags and restores the threshold.
// ----------------------------------------------------------------------------
module healthy_channel_top_two_selector_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hcts_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hcts_pkg::rsp_word_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [hcts_pkg::VOLT_W-1:0] csr_wr_data
);

   localparam int IDX_W  = hcts_pkg::IDX_W;
   localparam int VOLT_W = hcts_pkg::VOLT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(hcts_pkg::CHAN_COUNT - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   logic [VOLT_W-1:0] thr_ff;
   logic [hcts_pkg::CHAN_COUNT-1:0] reported_ff, reported_in;

   logic              have1_ff, have1_in, have2_ff, have2_in;
   logic [IDX_W-1:0]  b1_ff, b1_in, b2_ff, b2_in;
   logic [VOLT_W-1:0] v1_ff, v1_in, v2_ff, v2_in;

   logic              accept;
   logic              upd_ok;
   logic [31:0]       ch_wide;
   logic [IDX_W-1:0]  wr_addr;
   logic [VOLT_W-1:0] rd_data;
   logic              healthy;
   logic [VOLT_W:0]   sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ch_wide   = 32'(req_data.channel);
   assign wr_addr   = ch_wide[IDX_W-1:0];
   assign upd_ok    = accept && (req_data.req_type == hcts_pkg::REQ_UPDATE)
                      && (ch_wide < 32'(hcts_pkg::CHAN_COUNT));

   hcts_ram #(
      .WIDTH(VOLT_W),
      .DEPTH(hcts_pkg::CHAN_COUNT)
   ) u_volt_ram (
      .clock  (clock),
      .wr_en  (upd_ok),
      .wr_addr(wr_addr),
      .wr_data(req_data.voltage),
      .rd_addr(cnt_ff),
      .rd_data(rd_data)
   );

   // read data belongs to the index issued in the previous cycle
   assign healthy = proc_vld_ff && reported_ff[proc_idx_ff] && (rd_data > thr_ff);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      proc_vld_in = 1'b0;
      proc_idx_in = cnt_ff;
      reported_in = reported_ff;
      have1_in    = have1_ff;
      have2_in    = have2_ff;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      v1_in       = v1_ff;
      v2_in       = v2_ff;

      if (upd_ok) begin
         reported_in[wr_addr] = 1'b1;
      end

      if (healthy) begin
         if (!have1_ff || rd_data > v1_ff) begin
            if (have1_ff) begin
               b2_in    = b1_ff;
               v2_in    = v1_ff;
               have2_in = 1'b1;
            end
            b1_in    = proc_idx_ff;
            v1_in    = rd_data;
            have1_in = 1'b1;
         end else if (!have2_ff || rd_data > v2_ff) begin
            b2_in    = proc_idx_ff;
            v2_in    = rd_data;
            have2_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.req_type == hcts_pkg::REQ_TICK) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               have1_in = 1'b0;
               have2_in = 1'b0;
            end
         end
         ST_SCAN: begin
            proc_vld_in = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         proc_vld_ff <= 1'b0;
         reported_ff <= '0;
         thr_ff      <= hcts_pkg::THRESHOLD_RESET;
         have1_ff    <= 1'b0;
         have2_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         proc_vld_ff <= proc_vld_in;
         reported_ff <= reported_in;
         have1_ff    <= have1_in;
         have2_ff    <= have2_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      proc_idx_ff <= proc_idx_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
   end

   assign sum       = {1'b0, v1_ff} + {1'b0, v2_ff};
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      if (have2_ff) begin
         rsp_data.status         = hcts_pkg::STATUS_OK;
         rsp_data.best_channel   = hcts_pkg::CH_W'(b1_ff);
         rsp_data.second_channel = hcts_pkg::CH_W'(b2_ff);
         rsp_data.mean_voltage   = sum[VOLT_W:1];
      end else begin
         rsp_data.status         = hcts_pkg::STATUS_INSUFFICIENT;
         rsp_data.best_channel   = '0;
         rsp_data.second_channel = '0;
         rsp_data.mean_voltage   = '0;
      end
   end

endmodule
